// ----- src/vme_pkg.sv -----
// ============================================================================
// vme_pkg
// Shared types, codes and sizes for the variable machine execute unit.
// ============================================================================
package vme_pkg;

    localparam int WORD_BITS = 64;
    localparam int CNT_BITS  = $clog2(WORD_BITS);
    localparam int NUM_VARS  = 64;
    localparam int VAR_BITS  = $clog2(NUM_VARS);
    localparam int PC_BITS   = 12;

    localparam logic [3:0] OP_SET   = 4'd0;
    localparam logic [3:0] OP_OUT   = 4'd1;
    localparam logic [3:0] OP_ADD   = 4'd2;
    localparam logic [3:0] OP_SUB   = 4'd3;
    localparam logic [3:0] OP_MUL   = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_CMP   = 4'd6;
    localparam logic [3:0] OP_IF    = 4'd7;
    localparam logic [3:0] OP_GOTO  = 4'd8;
    localparam logic [3:0] OP_MARK  = 4'd9;
    localparam logic [3:0] OP_HALT  = 4'd10;

    localparam logic [2:0] CMP_EQ = 3'd0;
    localparam logic [2:0] CMP_NE = 3'd1;
    localparam logic [2:0] CMP_LT = 3'd2;
    localparam logic [2:0] CMP_LE = 3'd3;
    localparam logic [2:0] CMP_GT = 3'd4;
    localparam logic [2:0] CMP_GE = 3'd5;

    localparam logic [2:0] ST_RUNNING  = 3'd0;
    localparam logic [2:0] ST_HALTED   = 3'd1;
    localparam logic [2:0] ST_DIV_ZERO = 3'd2;
    localparam logic [2:0] ST_NO_LABEL = 3'd3;
    localparam logic [2:0] ST_BAD_CMP  = 3'd4;
    localparam logic [2:0] ST_BAD_OP   = 3'd5;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_CMP
    } alu_op_t;

    typedef struct packed {
        logic                 start;
        alu_op_t              op;
        logic [2:0]           cmp;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic                 done;
        logic [WORD_BITS-1:0] result;
    } alu_rsp_t;

endpackage

// ----- src/vme_varfile.sv -----
// ============================================================================
// vme_varfile
// Variable file with one write port, one registered read port and per-entry
// valid bits so that entries read as zero until first written.
// ============================================================================
module vme_varfile (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [vme_pkg::VAR_BITS-1:0]   wr_idx,
    input  logic [vme_pkg::WORD_BITS-1:0]  wr_data,
    input  logic [vme_pkg::VAR_BITS-1:0]   rd_idx,
    output logic [vme_pkg::WORD_BITS-1:0]  rd_data
);
    import vme_pkg::*;

    logic [WORD_BITS-1:0] mem [NUM_VARS];
    logic [NUM_VARS-1:0]  valid_reg;
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= valid_reg[rd_idx] ? mem[rd_idx] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/vme_alu.sv -----
// ============================================================================
// vme_alu
// Iterative arithmetic unit built around one 64-bit adder: add, subtract and
// compare in one step, multiply by shift-add and signed divide by restoring
// division, one bit per cycle.
// ============================================================================
module vme_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  vme_pkg::alu_req_t req,
    output vme_pkg::alu_rsp_t rsp
);
    import vme_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE,
        S_NEG_A,
        S_NEG_B,
        S_LOOP,
        S_FIX,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    alu_op_t              op_reg, op_next;
    logic [2:0]           cmp_reg, cmp_next;
    logic [WORD_BITS-1:0] x_reg, x_next;
    logic [WORD_BITS-1:0] y_reg, y_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;

    logic [WORD_BITS-1:0] add_x, add_y;
    logic                 add_inv;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS-1:0] shifted;
    logic                 eq, lt, rel;

    assign shifted = {acc_reg[WORD_BITS-2:0], x_reg[WORD_BITS-1]};

    always_comb
    begin
        add_x   = x_reg;
        add_y   = y_reg;
        add_inv = 1'b0;
        unique case (state_reg)
            S_ONE:
            begin
                add_inv = (op_reg != ALU_ADD);
            end
            S_NEG_A, S_FIX:
            begin
                add_x   = '0;
                add_y   = x_reg;
                add_inv = 1'b1;
            end
            S_NEG_B:
            begin
                add_x   = '0;
                add_y   = y_reg;
                add_inv = 1'b1;
            end
            S_LOOP:
            begin
                if (op_reg == ALU_MUL)
                begin
                    add_x = acc_reg;
                    add_y = x_reg;
                end
                else
                begin
                    add_x   = shifted;
                    add_y   = y_reg;
                    add_inv = 1'b1;
                end
            end
            default:
            begin
                add_inv = 1'b0;
            end
        endcase
    end

    assign sum = {1'b0, add_x} + {1'b0, add_y ^ {WORD_BITS{add_inv}}}
                 + {{WORD_BITS{1'b0}}, add_inv};

    assign eq = (sum[WORD_BITS-1:0] == '0);
    assign lt = (x_reg[WORD_BITS-1] != y_reg[WORD_BITS-1]) ? x_reg[WORD_BITS-1]
                                                           : sum[WORD_BITS-1];

    always_comb
    begin
        unique case (cmp_reg)
            CMP_EQ:  rel = eq;
            CMP_NE:  rel = !eq;
            CMP_LT:  rel = lt;
            CMP_LE:  rel = lt || eq;
            CMP_GT:  rel = !(lt || eq);
            default: rel = !lt;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmp_next   = cmp_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    cmp_next = req.cmp;
                    x_next   = req.a;
                    y_next   = req.b;
                    acc_next = '0;
                    cnt_next = '0;
                    unique case (req.op)
                        ALU_MUL: state_next = S_LOOP;
                        ALU_DIV: state_next = S_NEG_A;
                        default: state_next = S_ONE;
                    endcase
                end
            end
            S_ONE:
            begin
                if (op_reg == ALU_CMP)
                begin
                    acc_next = {{(WORD_BITS-1){1'b0}}, rel};
                end
                else
                begin
                    acc_next = sum[WORD_BITS-1:0];
                end
                state_next = S_DONE;
            end
            S_NEG_A:
            begin
                neg_next = x_reg[WORD_BITS-1] ^ y_reg[WORD_BITS-1];
                if (x_reg[WORD_BITS-1])
                begin
                    x_next = sum[WORD_BITS-1:0];
                end
                state_next = S_NEG_B;
            end
            S_NEG_B:
            begin
                if (y_reg[WORD_BITS-1])
                begin
                    y_next = sum[WORD_BITS-1:0];
                end
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if (op_reg == ALU_MUL)
                begin
                    if (y_reg[0])
                    begin
                        acc_next = sum[WORD_BITS-1:0];
                    end
                    x_next = {x_reg[WORD_BITS-2:0], 1'b0};
                    y_next = {1'b0, y_reg[WORD_BITS-1:1]};
                end
                else
                begin
                    acc_next = sum[WORD_BITS] ? sum[WORD_BITS-1:0] : shifted;
                    x_next   = {x_reg[WORD_BITS-2:0], sum[WORD_BITS]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == {CNT_BITS{1'b1}})
                begin
                    state_next = (op_reg == ALU_MUL) ? S_DONE : S_FIX;
                end
            end
            S_FIX:
            begin
                acc_next   = neg_reg ? sum[WORD_BITS-1:0] : x_reg;
                state_next = S_DONE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= ALU_ADD;
            cmp_reg   <= CMP_EQ;
            x_reg     <= '0;
            y_reg     <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cmp_reg   <= cmp_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            neg_reg   <= neg_next;
        end
    end

    assign rsp.done   = (state_reg == S_DONE);
    assign rsp.result = acc_reg;

endmodule

// ----- src/variable_machine_execute.sv -----
// ============================================================================
// variable_machine_execute
// Executes one decoded instruction per item against a file of signed 64-bit
// variables and keeps the program counter and run status.
//
//   Channel   Handshake            Payload
//   input     in_valid, in_ready   req_type ... target_found
//   result    res_valid, res_ready next_pc, out_valid, out_value, run_status
//
// A stopped machine goes from acceptance straight to the finish state. Otherwise
// items read operands, execute and finish; add, subtract, multiply, a valid compare
// and a nonzero divide wait on the ALU, multiply and divide for 64 shared-adder steps.
// Operands are read one per cycle from the variable file's single read port.
// Reset clears the variables, the program counter and the status at once. A
// waiting result stalls only the end of the next item; input is taken when idle.
// ============================================================================
module variable_machine_execute (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  req_type,
    input  logic [5:0]  dest_var,
    input  logic        a_is_literal,
    input  logic [5:0]  a_var,
    input  logic [63:0] a_literal,
    input  logic        b_is_literal,
    input  logic [5:0]  b_var,
    input  logic [63:0] b_literal,
    input  logic [2:0]  cmp_op,
    input  logic [11:0] jump_target,
    input  logic        target_found,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [11:0] next_pc,
    output logic        out_valid,
    output logic [63:0] out_value,
    output logic [2:0]  run_status
);
    import vme_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_EXEC,
        S_WAIT,
        S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [3:0]           op_reg, op_next;
    logic [VAR_BITS-1:0]  dest_reg, dest_next;
    logic                 a_lit_reg, a_lit_next;
    logic [VAR_BITS-1:0]  a_idx_reg, a_idx_next;
    logic [WORD_BITS-1:0] a_val_reg, a_val_next;
    logic                 b_lit_reg, b_lit_next;
    logic [VAR_BITS-1:0]  b_idx_reg, b_idx_next;
    logic [WORD_BITS-1:0] b_val_reg, b_val_next;
    logic [2:0]           cmp_reg, cmp_next;
    logic [PC_BITS-1:0]   target_reg, target_next;
    logic                 found_reg, found_next;
    logic [WORD_BITS-1:0] avar_reg, avar_next;

    logic [PC_BITS-1:0]   pc_reg, pc_next;
    logic [2:0]           stop_reg, stop_next;

    logic [PC_BITS-1:0]   fin_pc_reg, fin_pc_next;
    logic                 fin_ov_reg, fin_ov_next;
    logic [WORD_BITS-1:0] fin_val_reg, fin_val_next;
    logic [2:0]           fin_stat_reg, fin_stat_next;
    logic                 wr_en_reg, wr_en_next;
    logic [WORD_BITS-1:0] wr_data_reg, wr_data_next;

    logic                 res_valid_reg, res_valid_next;
    logic [11:0]          res_pc_reg, res_pc_next;
    logic                 res_ov_reg, res_ov_next;
    logic [WORD_BITS-1:0] res_val_reg, res_val_next;
    logic [2:0]           res_stat_reg, res_stat_next;

    logic [VAR_BITS-1:0]  rd_idx;
    logic [WORD_BITS-1:0] rd_data;
    logic                 finish_fire;
    logic [WORD_BITS-1:0] a_op, b_op;
    logic [PC_BITS-1:0]   pc_inc;
    alu_req_t             alu_req;
    alu_rsp_t             alu_rsp;

    vme_varfile u_varfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (finish_fire && wr_en_reg),
        .wr_idx  (dest_reg),
        .wr_data (wr_data_reg),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    vme_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign rd_idx      = (state_reg == S_RD_A) ? a_idx_reg : b_idx_reg;
    assign finish_fire = (state_reg == S_FINISH) && (!res_valid_reg || res_ready);
    assign a_op        = a_lit_reg ? a_val_reg : avar_reg;
    assign b_op        = b_lit_reg ? b_val_reg : rd_data;
    assign pc_inc      = pc_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        dest_next      = dest_reg;
        a_lit_next     = a_lit_reg;
        a_idx_next     = a_idx_reg;
        a_val_next     = a_val_reg;
        b_lit_next     = b_lit_reg;
        b_idx_next     = b_idx_reg;
        b_val_next     = b_val_reg;
        cmp_next       = cmp_reg;
        target_next    = target_reg;
        found_next     = found_reg;
        avar_next      = avar_reg;
        pc_next        = pc_reg;
        stop_next      = stop_reg;
        fin_pc_next    = fin_pc_reg;
        fin_ov_next    = fin_ov_reg;
        fin_val_next   = fin_val_reg;
        fin_stat_next  = fin_stat_reg;
        wr_en_next     = wr_en_reg;
        wr_data_next   = wr_data_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_pc_next    = res_pc_reg;
        res_ov_next    = res_ov_reg;
        res_val_next   = res_val_reg;
        res_stat_next  = res_stat_reg;
        alu_req.start  = 1'b0;
        alu_req.op     = ALU_ADD;
        alu_req.cmp    = cmp_reg;
        alu_req.a      = a_op;
        alu_req.b      = b_op;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = req_type;
                    dest_next   = dest_var[VAR_BITS-1:0];
                    a_lit_next  = a_is_literal;
                    a_idx_next  = a_var[VAR_BITS-1:0];
                    a_val_next  = a_literal;
                    b_lit_next  = b_is_literal;
                    b_idx_next  = b_var[VAR_BITS-1:0];
                    b_val_next  = b_literal;
                    cmp_next    = cmp_op;
                    target_next = jump_target[PC_BITS-1:0];
                    found_next  = target_found;
                    if (stop_reg != ST_RUNNING)
                    begin
                        fin_pc_next   = pc_reg;
                        fin_ov_next   = 1'b0;
                        fin_val_next  = '0;
                        fin_stat_next = stop_reg;
                        wr_en_next    = 1'b0;
                        state_next    = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_RD_A;
                    end
                end
            end
            S_RD_A:
            begin
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                avar_next  = rd_data;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                b_val_next    = b_op;
                fin_pc_next   = pc_inc;
                fin_ov_next   = 1'b0;
                fin_val_next  = '0;
                fin_stat_next = ST_RUNNING;
                wr_en_next    = 1'b0;
                wr_data_next  = a_op;
                state_next    = S_FINISH;
                unique case (op_reg)
                    OP_SET:
                    begin
                        wr_en_next = 1'b1;
                    end
                    OP_OUT:
                    begin
                        fin_ov_next  = 1'b1;
                        fin_val_next = a_op;
                    end
                    OP_ADD, OP_SUB, OP_MUL:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = (op_reg == OP_ADD) ? ALU_ADD :
                                        (op_reg == OP_SUB) ? ALU_SUB : ALU_MUL;
                        state_next    = S_WAIT;
                    end
                    OP_DIV:
                    begin
                        if (b_op == '0)
                        begin
                            fin_pc_next   = pc_reg;
                            fin_stat_next = ST_DIV_ZERO;
                        end
                        else
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_DIV;
                            state_next    = S_WAIT;
                        end
                    end
                    OP_CMP:
                    begin
                        if (cmp_reg > CMP_GE)
                        begin
                            fin_pc_next   = pc_reg;
                            fin_stat_next = ST_BAD_CMP;
                        end
                        else
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_CMP;
                            state_next    = S_WAIT;
                        end
                    end
                    OP_IF, OP_GOTO:
                    begin
                        if ((op_reg == OP_GOTO) || (avar_reg != '0))
                        begin
                            if (found_reg)
                            begin
                                fin_pc_next = target_reg;
                            end
                            else
                            begin
                                fin_pc_next   = pc_reg;
                                fin_stat_next = ST_NO_LABEL;
                            end
                        end
                    end
                    OP_MARK:
                    begin
                        fin_pc_next = pc_inc;
                    end
                    OP_HALT:
                    begin
                        fin_pc_next   = pc_reg;
                        fin_stat_next = ST_HALTED;
                    end
                    default:
                    begin
                        fin_pc_next   = pc_reg;
                        fin_stat_next = ST_BAD_OP;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    wr_en_next   = 1'b1;
                    wr_data_next = alu_rsp.result;
                    state_next   = S_FINISH;
                end
            end
            default:
            begin
                if (finish_fire)
                begin
                    pc_next        = fin_pc_reg;
                    stop_next      = fin_stat_reg;
                    res_valid_next = 1'b1;
                    res_pc_next    = 12'(fin_pc_reg);
                    res_ov_next    = fin_ov_reg;
                    res_val_next   = fin_val_reg;
                    res_stat_next  = fin_stat_reg;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_SET;
            dest_reg      <= '0;
            a_lit_reg     <= 1'b0;
            a_idx_reg     <= '0;
            a_val_reg     <= '0;
            b_lit_reg     <= 1'b0;
            b_idx_reg     <= '0;
            b_val_reg     <= '0;
            cmp_reg       <= CMP_EQ;
            target_reg    <= '0;
            found_reg     <= 1'b0;
            avar_reg      <= '0;
            pc_reg        <= '0;
            stop_reg      <= ST_RUNNING;
            fin_pc_reg    <= '0;
            fin_ov_reg    <= 1'b0;
            fin_val_reg   <= '0;
            fin_stat_reg  <= ST_RUNNING;
            wr_en_reg     <= 1'b0;
            wr_data_reg   <= '0;
            res_valid_reg <= 1'b0;
            res_pc_reg    <= '0;
            res_ov_reg    <= 1'b0;
            res_val_reg   <= '0;
            res_stat_reg  <= ST_RUNNING;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            dest_reg      <= dest_next;
            a_lit_reg     <= a_lit_next;
            a_idx_reg     <= a_idx_next;
            a_val_reg     <= a_val_next;
            b_lit_reg     <= b_lit_next;
            b_idx_reg     <= b_idx_next;
            b_val_reg     <= b_val_next;
            cmp_reg       <= cmp_next;
            target_reg    <= target_next;
            found_reg     <= found_next;
            avar_reg      <= avar_next;
            pc_reg        <= pc_next;
            stop_reg      <= stop_next;
            fin_pc_reg    <= fin_pc_next;
            fin_ov_reg    <= fin_ov_next;
            fin_val_reg   <= fin_val_next;
            fin_stat_reg  <= fin_stat_next;
            wr_en_reg     <= wr_en_next;
            wr_data_reg   <= wr_data_next;
            res_valid_reg <= res_valid_next;
            res_pc_reg    <= res_pc_next;
            res_ov_reg    <= res_ov_next;
            res_val_reg   <= res_val_next;
            res_stat_reg  <= res_stat_next;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = res_valid_reg;
    assign next_pc    = res_pc_reg;
    assign out_valid  = res_ov_reg;
    assign out_value  = res_val_reg;
    assign run_status = res_stat_reg;

endmodule

// ----- tb/tb_variable_machine_execute.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_variable_machine_execute
// Self-checking testbench for the variable machine execute unit. A shadow
// copy of the variable file, program counter and stop code is updated for
// every accepted item and gives the next pc, output and status that the
// block must return. Directed programs cover unset variables, wrapping
// arithmetic, division corner cases, every compare relation and the jumps.
// A long random program follows, and the run closes with one randomly
// chosen halt or error followed by items that must be ignored.
// ============================================================================
module tb_variable_machine_execute;
    import vme_pkg::*;

    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          RANDOM_ITEMS = 1250;
    localparam logic [63:0] WORD_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] WORD_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] WORD_NEG1    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [2:0]  CMP_BAD_LO   = 3'd6;
    localparam logic [2:0]  CMP_BAD_HI   = 3'd7;
    localparam logic [3:0]  OP_UNDEF_LO  = 4'd11;
    localparam logic [3:0]  OP_UNDEF_HI  = 4'd15;

    typedef struct {
        logic [3:0]  req_type;
        logic [5:0]  dest_var;
        logic        a_is_literal;
        logic [5:0]  a_var;
        logic [63:0] a_literal;
        logic        b_is_literal;
        logic [5:0]  b_var;
        logic [63:0] b_literal;
        logic [2:0]  cmp_op;
        logic [11:0] jump_target;
        logic        target_found;
    } instr_t;

    typedef struct {
        logic [11:0] next_pc;
        logic        out_valid;
        logic [63:0] out_value;
        logic [2:0]  run_status;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  req_type;
    logic [5:0]  dest_var;
    logic        a_is_literal;
    logic [5:0]  a_var;
    logic [63:0] a_literal;
    logic        b_is_literal;
    logic [5:0]  b_var;
    logic [63:0] b_literal;
    logic [2:0]  cmp_op;
    logic [11:0] jump_target;
    logic        target_found;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [11:0] next_pc;
    logic        out_valid;
    logic [63:0] out_value;
    logic [2:0]  run_status;

    logic [63:0]        shadow_vars [NUM_VARS];
    logic [PC_BITS-1:0] shadow_pc;
    logic [2:0]         shadow_stop;
    outcome_t           machine_outcomes [$];

    logic idle_on;
    int   error_count;
    int   items_sent;
    int   results_seen;
    int   outputs_seen;
    int   cycle_count;
    int   stall_left;

    variable_machine_execute u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] operand_value(input logic lit_sel, input logic [5:0] idx,
                                                  input logic [63:0] lit);
        return lit_sel ? lit : shadow_vars[idx % NUM_VARS];
    endfunction

    function automatic outcome_t apply_instruction(input instr_t it);
        outcome_t           o;
        logic [63:0]        a;
        logic [63:0]        b;
        logic [5:0]         d;
        logic [PC_BITS-1:0] nxt;
        a = operand_value(it.a_is_literal, it.a_var, it.a_literal);
        b = operand_value(it.b_is_literal, it.b_var, it.b_literal);
        d = 6'(it.dest_var % NUM_VARS);
        nxt = shadow_pc + 1'b1;
        o.out_valid = 1'b0;
        o.out_value = '0;
        if (shadow_stop == ST_RUNNING)
        begin
            case (it.req_type)
                OP_SET: shadow_vars[d] = a;
                OP_OUT:
                begin
                    o.out_valid = 1'b1;
                    o.out_value = a;
                end
                OP_ADD: shadow_vars[d] = a + b;
                OP_SUB: shadow_vars[d] = a - b;
                OP_MUL: shadow_vars[d] = a * b;
                OP_DIV:
                begin
                    if (b == '0)
                    begin
                        shadow_stop = ST_DIV_ZERO;
                        nxt = shadow_pc;
                    end
                    else if (b == WORD_NEG1)
                        shadow_vars[d] = -a;
                    else
                        shadow_vars[d] = $signed(a) / $signed(b);
                end
                OP_CMP:
                begin
                    case (it.cmp_op)
                        CMP_EQ: shadow_vars[d] = {63'd0, a == b};
                        CMP_NE: shadow_vars[d] = {63'd0, a != b};
                        CMP_LT: shadow_vars[d] = {63'd0, $signed(a) < $signed(b)};
                        CMP_LE: shadow_vars[d] = {63'd0, $signed(a) <= $signed(b)};
                        CMP_GT: shadow_vars[d] = {63'd0, $signed(a) > $signed(b)};
                        CMP_GE: shadow_vars[d] = {63'd0, $signed(a) >= $signed(b)};
                        default:
                        begin
                            shadow_stop = ST_BAD_CMP;
                            nxt = shadow_pc;
                        end
                    endcase
                end
                OP_IF, OP_GOTO:
                begin
                    if (it.req_type == OP_GOTO || shadow_vars[it.a_var % NUM_VARS] != '0)
                    begin
                        if (!it.target_found)
                        begin
                            shadow_stop = ST_NO_LABEL;
                            nxt = shadow_pc;
                        end
                        else
                            nxt = it.jump_target[PC_BITS-1:0];
                    end
                end
                OP_MARK: ;
                OP_HALT:
                begin
                    shadow_stop = ST_HALTED;
                    nxt = shadow_pc;
                end
                default:
                begin
                    shadow_stop = ST_BAD_OP;
                    nxt = shadow_pc;
                end
            endcase
            shadow_pc = nxt;
        end
        o.next_pc = 12'(shadow_pc);
        o.run_status = shadow_stop;
        return o;
    endfunction

    function automatic instr_t make_instr(input logic [3:0] op, input logic [5:0] dest,
                                          input logic a_sel, input logic [5:0] av,
                                          input logic [63:0] alit, input logic b_sel,
                                          input logic [5:0] bv, input logic [63:0] blit);
        instr_t it;
        it.req_type = op;
        it.dest_var = dest;
        it.a_is_literal = a_sel;
        it.a_var = av;
        it.a_literal = alit;
        it.b_is_literal = b_sel;
        it.b_var = bv;
        it.b_literal = blit;
        it.cmp_op = CMP_EQ;
        it.jump_target = '0;
        it.target_found = 1'b0;
        return it;
    endfunction

    function automatic logic [63:0] random_word();
        logic [15:0] s;
        s = 16'($urandom());
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return 64'd1;
            2: return WORD_NEG1;
            3: return WORD_MIN;
            4: return WORD_MAX;
            5: return {{48{s[15]}}, s};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Most indexes come from a small pool so that reads usually hit written values.
    function automatic logic [5:0] random_var();
        if ($urandom_range(0, 3) == 0)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, 7));
    endfunction

    function automatic instr_t random_instr();
        instr_t it;
        int     r;
        r = $urandom_range(0, 99);
        it = make_instr(OP_MARK, random_var(), 1'($urandom()), random_var(), random_word(),
                        1'($urandom()), random_var(), random_word());
        it.cmp_op = 3'($urandom_range(CMP_EQ, CMP_GE));
        it.jump_target = 12'($urandom());
        it.target_found = 1'($urandom());
        if (r < 14)
            it.req_type = OP_SET;
        else if (r < 24)
            it.req_type = OP_OUT;
        else if (r < 36)
            it.req_type = OP_ADD;
        else if (r < 48)
            it.req_type = OP_SUB;
        else if (r < 56)
            it.req_type = OP_MUL;
        else if (r < 66)
            it.req_type = OP_DIV;
        else if (r < 80)
            it.req_type = OP_CMP;
        else if (r < 88)
            it.req_type = OP_IF;
        else if (r < 94)
            it.req_type = OP_GOTO;
        if (it.req_type == OP_DIV &&
            operand_value(it.b_is_literal, it.b_var, it.b_literal) == '0)
        begin
            it.b_is_literal = 1'b1;
            it.b_literal = {$urandom(), $urandom() | 32'd1};
        end
        if (it.req_type == OP_GOTO ||
            (it.req_type == OP_IF && shadow_vars[it.a_var % NUM_VARS] != '0))
            it.target_found = 1'b1;
        return it;
    endfunction

    task automatic send_instr(input instr_t it);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type     <= it.req_type;
        dest_var     <= it.dest_var;
        a_is_literal <= it.a_is_literal;
        a_var        <= it.a_var;
        a_literal    <= it.a_literal;
        b_is_literal <= it.b_is_literal;
        b_var        <= it.b_var;
        b_literal    <= it.b_literal;
        cmp_op       <= it.cmp_op;
        jump_target  <= it.jump_target;
        target_found <= it.target_found;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        machine_outcomes.push_back(apply_instruction(it));
        items_sent++;
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= 30)
            $display("MISMATCH result %0d %s: got %h, want %h", results_seen, field, got, want);
    endtask

    task automatic test_unset_reads();
        send_instr(make_instr(OP_OUT, 6'd0, 1'b0, 6'd63, WORD_MAX, 1'b0, 6'd0, '0));
        send_instr(make_instr(OP_ADD, 6'd63, 1'b0, 6'd5, '0, 1'b0, 6'd62, '0));
        send_instr(make_instr(OP_OUT, 6'd0, 1'b1, 6'd0, WORD_MIN, 1'b0, 6'd0, '0));
    endtask

    task automatic test_arith_extremes();
        send_instr(make_instr(OP_SET, 6'd1, 1'b1, 6'd0, WORD_MAX, 1'b0, 6'd0, '0));
        send_instr(make_instr(OP_SET, 6'd2, 1'b1, 6'd0, WORD_MIN, 1'b0, 6'd0, '0));
        send_instr(make_instr(OP_ADD, 6'd3, 1'b0, 6'd1, '0, 1'b1, 6'd0, 64'd1));
        send_instr(make_instr(OP_SUB, 6'd4, 1'b0, 6'd2, '0, 1'b1, 6'd0, 64'd1));
        send_instr(make_instr(OP_MUL, 6'd5, 1'b0, 6'd1, '0, 1'b0, 6'd1, '0));
        send_instr(make_instr(OP_MUL, 6'd6, 1'b0, 6'd2, '0, 1'b1, 6'd0, WORD_NEG1));
        send_instr(make_instr(OP_DIV, 6'd7, 1'b0, 6'd2, '0, 1'b1, 6'd0, WORD_NEG1));
        send_instr(make_instr(OP_DIV, 6'd8, 1'b1, 6'd0, -64'sd7, 1'b1, 6'd0, 64'd2));
        send_instr(make_instr(OP_DIV, 6'd9, 1'b1, 6'd0, 64'd7, 1'b1, 6'd0, -64'sd2));
        send_instr(make_instr(OP_OUT, 6'd0, 1'b0, 6'd4, '0, 1'b0, 6'd0, '0));
    endtask

    task automatic test_compare_relations();
        instr_t it;
        for (int rel = CMP_EQ; rel <= CMP_GE; rel++)
        begin
            it = make_instr(OP_CMP, 6'd10, 1'b0, 6'd2, '0, 1'b0, 6'd1, '0);
            it.cmp_op = 3'(rel);
            send_instr(it);
        end
        it = make_instr(OP_CMP, 6'd11, 1'b0, 6'd3, '0, 1'b1, 6'd0, WORD_MIN);
        it.cmp_op = CMP_EQ;
        send_instr(it);
    endtask

    task automatic test_jumps();
        instr_t it;
        it = make_instr(OP_IF, 6'd0, 1'b1, 6'd0, WORD_NEG1, 1'b0, 6'd0, '0);
        it.jump_target = 12'd5;
        send_instr(it);
        send_instr(make_instr(OP_SET, 6'd63, 1'b1, 6'd0, 64'd1, 1'b0, 6'd0, '0));
        it = make_instr(OP_IF, 6'd0, 1'b0, 6'd63, '0, 1'b0, 6'd0, '0);
        it.jump_target = 12'hFFF;
        it.target_found = 1'b1;
        send_instr(it);
        send_instr(make_instr(OP_MARK, 6'd0, 1'b0, 6'd0, '0, 1'b0, 6'd0, '0));
        it = make_instr(OP_GOTO, 6'd63, 1'b1, 6'd63, WORD_NEG1, 1'b1, 6'd63, WORD_NEG1);
        it.jump_target = 12'hFFE;
        it.target_found = 1'b1;
        send_instr(it);
        send_instr(make_instr(OP_OUT, 6'd0, 1'b0, 6'd63, '0, 1'b0, 6'd0, '0));
    endtask

    task automatic test_random_program(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n == count - count / 6)
                idle_on <= 1'b0;
            send_instr(random_instr());
        end
    endtask

    task automatic test_stop_and_ignore();
        instr_t it;
        it = random_instr();
        case ($urandom_range(0, 5))
            0: it.req_type = OP_HALT;
            1:
            begin
                it.req_type = OP_DIV;
                it.b_is_literal = 1'b1;
                it.b_literal = '0;
            end
            2:
            begin
                it.req_type = OP_CMP;
                it.cmp_op = $urandom_range(0, 1) ? CMP_BAD_LO : CMP_BAD_HI;
            end
            3:
            begin
                send_instr(make_instr(OP_SET, it.a_var, 1'b1, 6'd0, 64'd1, 1'b0, 6'd0, '0));
                it.req_type = OP_IF;
                it.target_found = 1'b0;
            end
            4:
            begin
                it.req_type = OP_GOTO;
                it.target_found = 1'b0;
            end
            default: it.req_type = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        endcase
        send_instr(it);
        repeat (8)
        begin
            it = random_instr();
            it.req_type = 4'($urandom_range(OP_SET, OP_UNDEF_HI));
            it.cmp_op = 3'($urandom());
            it.target_found = 1'($urandom());
            send_instr(it);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            res_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            res_ready <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && res_valid && res_ready)
        begin
            results_seen++;
            if (machine_outcomes.size() == 0)
                report_mismatch("arrived with none pending", {52'd0, next_pc}, '0);
            else
            begin
                want = machine_outcomes.pop_front();
                if (out_valid === 1'b1)
                    outputs_seen++;
                if (next_pc !== want.next_pc)
                    report_mismatch("next_pc", {52'd0, next_pc}, {52'd0, want.next_pc});
                if (out_valid !== want.out_valid)
                    report_mismatch("out_valid", {63'd0, out_valid}, {63'd0, want.out_valid});
                if (out_value !== want.out_value)
                    report_mismatch("out_value", out_value, want.out_value);
                if (run_status !== want.run_status)
                    report_mismatch("run_status", {61'd0, run_status}, {61'd0, want.run_status});
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** variable_machine_execute: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = OP_SET;
        dest_var = '0;
        a_is_literal = 1'b0;
        a_var = '0;
        a_literal = '0;
        b_is_literal = 1'b0;
        b_var = '0;
        b_literal = '0;
        cmp_op = CMP_EQ;
        jump_target = '0;
        target_found = 1'b0;
        idle_on = 1'b1;
        items_sent = 0;
        for (int i = 0; i < NUM_VARS; i++)
            shadow_vars[i] = '0;
        shadow_pc = '0;
        shadow_stop = ST_RUNNING;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unset_reads();
        test_arith_extremes();
        test_compare_relations();
        test_jumps();
        test_random_program(RANDOM_ITEMS);
        test_stop_and_ignore();
        in_valid <= 1'b0;
        while (machine_outcomes.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Ran %0d items through directed and random programs;", items_sent);
        $display("%0d results checked, %0d with output.", results_seen, outputs_seen);
        $display("The closing stop case left the machine in status %0d at pc %0d.",
                 shadow_stop, shadow_pc);
        if (error_count == 0)
            $display("** variable_machine_execute: PASSED **");
        else
            $display("** variable_machine_execute: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
src/vme_pkg.sv
src/vme_varfile.sv
src/vme_alu.sv
src/variable_machine_execute.sv
tb/tb_variable_machine_execute.sv
